// ----- hdl/rbd_pkg.sv -----
// Shared types and constants for the RecordIO byte deframer.
package rbd_pkg;

	// Header layout
	localparam int unsigned LENGTH_BITS = 29;
	localparam logic [31:0] MAGIC_WORD = 32'hced7230a;
	localparam int unsigned FLAG_LSB = 29;
	localparam int unsigned HDR_BYTES = 8;
	localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);

	// Result kinds
	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_EMPTY     = 2'd1;
	localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [1:0] KIND_BAD_FLAG  = 2'd3;

	// Result queue geometry
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [LENGTH_BITS-1:0] len_t;

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} rbd_item_t;

	// Push side of the result queue
	typedef struct packed {
		logic      valid;
		rbd_item_t item;
	} rbd_push_t;

	// Pop side of the result queue
	typedef struct packed {
		logic      not_empty;
		rbd_item_t item;
	} rbd_head_t;

endpackage

// ----- hdl/rbd_front.sv -----
// Front end: gathers headers, counts payload and padding, classifies each byte.
module rbd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          stream_byte,
	output rbd_pkg::rbd_push_t  push
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_PADDING = 2'd2;
	localparam logic [1:0] PH_HALTED  = 2'd3;

	localparam int unsigned HDR_W = 8 * rbd_pkg::HDR_BYTES;
	localparam rbd_pkg::len_t LEN_ONE = {{(rbd_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};

	logic [1:0]                     phase_q;
	logic [rbd_pkg::HDR_CNT_W-1:0]  hdr_cnt_q;
	logic [HDR_W-1:0]               hdr_q;
	rbd_pkg::len_t                  pay_left_q;
	logic [1:0]                     pad_left_q;

	logic [HDR_W-1:0]  hdr_full;
	logic              hdr_done;
	logic              magic_ok;
	logic              flag_ok;
	rbd_pkg::len_t     rec_len;
	logic              len_zero;
	logic              pay_last;

	// Header bytes arrive low byte first; shift them in from the top
	assign hdr_full = {stream_byte, hdr_q[HDR_W-1:8]};
	assign hdr_done = (hdr_cnt_q == rbd_pkg::HDR_CNT_W'(rbd_pkg::HDR_BYTES - 1));
	assign magic_ok = (hdr_full[31:0] == rbd_pkg::MAGIC_WORD);
	assign flag_ok  = (hdr_full[32+rbd_pkg::FLAG_LSB +: 3] == 3'd0);
	assign rec_len  = hdr_full[32 +: rbd_pkg::LENGTH_BITS];
	assign len_zero = (rec_len == '0);
	assign pay_last = (pay_left_q == LEN_ONE);

	// Classify the current byte into a result, if any
	always_comb begin
		push.valid     = 1'b0;
		push.item.kind = rbd_pkg::KIND_DATA;
		push.item.data = 8'd0;
		push.item.last = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (accept && hdr_done) begin
					push.valid = !magic_ok || !flag_ok || len_zero;
					if (!magic_ok) begin
						push.item.kind = rbd_pkg::KIND_BAD_MAGIC;
					end else if (!flag_ok) begin
						push.item.kind = rbd_pkg::KIND_BAD_FLAG;
					end else begin
						push.item.kind = rbd_pkg::KIND_EMPTY;
						push.item.last = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				push.valid     = accept;
				push.item.data = stream_byte;
				push.item.last = pay_last;
			end
			default: begin
				push.valid = 1'b0;
			end
		endcase
	end

	// Header shift register holds no control state
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_HEADER) begin
			hdr_q <= hdr_full;
		end
	end

	// Advance the record state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_cnt_q  <= '0;
			pay_left_q <= '0;
			pad_left_q <= 2'd0;
		end else if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_cnt_q <= hdr_cnt_q + 1'b1;
					if (hdr_done) begin
						if (!magic_ok || !flag_ok) begin
							phase_q <= PH_HALTED;
						end else if (!len_zero) begin
							phase_q    <= PH_PAYLOAD;
							pay_left_q <= rec_len;
							pad_left_q <= 2'd0 - rec_len[1:0];
						end
					end
				end
				PH_PAYLOAD: begin
					pay_left_q <= pay_left_q - LEN_ONE;
					if (pay_last) begin
						phase_q <= (pad_left_q != 2'd0) ? PH_PADDING : PH_HEADER;
					end
				end
				PH_PADDING: begin
					pad_left_q <= pad_left_q - 2'd1;
					if (pad_left_q == 2'd1) begin
						phase_q <= PH_HEADER;
					end
				end
				default: begin
					phase_q <= PH_HALTED;
				end
			endcase
		end
	end

endmodule

// ----- hdl/rbd_queue.sv -----
// Short result queue between the front end and the output stage.
module rbd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  rbd_pkg::rbd_push_t push,
	input  logic               pop,
	output rbd_pkg::rbd_head_t head,
	output logic               full
);

	rbd_pkg::rbd_item_t                 slot_q [rbd_pkg::QUEUE_DEPTH];
	logic [rbd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q;
	logic [rbd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q;
	logic [rbd_pkg::QUEUE_PTR_W:0]      count_q;
	logic                               do_pop;

	assign full           = (count_q == (rbd_pkg::QUEUE_PTR_W+1)'(rbd_pkg::QUEUE_DEPTH));
	assign head.not_empty = (count_q != '0);
	assign head.item      = slot_q[rd_ptr_q];
	assign do_pop         = pop && head.not_empty;

	// Write the pushed item into its slot
	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/rbd_back.sv -----
// Output stage: registers the queue head and offers it on the result channel.
module rbd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  rbd_pkg::rbd_head_t head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output rbd_pkg::rbd_item_t result
);

	logic               valid_q;
	rbd_pkg::rbd_item_t item_q;
	logic               load;

	// Refill when the register is empty or its transfer completes
	assign load         = !valid_q || !result_stall;
	assign pop          = load && head.not_empty;
	assign result_valid = valid_q;
	assign result       = item_q;

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
		end
	end

	// Track output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= head.not_empty;
		end
	end

endmodule

// ----- hdl/recordio_byte_deframer.sv -----
// Top level of the RecordIO byte deframer: front end, result queue, output stage.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_stall      stream_byte[7:0]
//   result    out        result_valid / result_stall  result_kind[1:0], payload_byte[7:0],
//                                                     record_last
//
// One byte is taken per cycle unless byte_stall is high; the front end's per-byte state
// update sets that rate. A result is written into the queue at its byte's transfer edge
// and then, once the output register is free, into that register for the result port.
// byte_stall rises only while the four-entry result queue is full. Reset clears
// record state, queue and output valid; after an error result all bytes are still
// taken and dropped until the next reset.
module recordio_byte_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] stream_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] result_kind,
	output logic [7:0] payload_byte,
	output logic       record_last
);

	logic               accept;
	logic               q_full;
	logic               q_pop;
	rbd_pkg::rbd_push_t push;
	rbd_pkg::rbd_head_t head;
	rbd_pkg::rbd_item_t result;

	assign byte_stall   = q_full;
	assign accept       = byte_valid && !q_full;
	assign result_kind  = result.kind;
	assign payload_byte = result.data;
	assign record_last  = result.last;

	rbd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.stream_byte(stream_byte),
		.push       (push)
	);

	rbd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (q_pop),
		.head  (head),
		.full  (q_full)
	);

	rbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// Front end never writes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push.valid |-> !q_full)
		else $error("result pushed into full queue");

	// Non-data results carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind != rbd_pkg::KIND_DATA |-> payload_byte == 8'd0)
		else $error("non-data result with nonzero byte");

	// Error results never close a record
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == rbd_pkg::KIND_BAD_MAGIC ||
		result_kind == rbd_pkg::KIND_BAD_FLAG) |-> !record_last)
		else $error("error result marked last");

	// An empty-queue output stage with nothing pending goes idle
	assert property (@(posedge clk) disable iff (!arst_n)
		!head.not_empty && !push.valid && (!result_valid || !result_stall) |=> !result_valid)
		else $error("output valid without a queued result");

endmodule
